@@ sv/mct_pkg.sv @@
// Shared types and constants for the 4x4 matrix column transform.
`default_nettype none
package mct_pkg;

  localparam int DIM    = 4;
  localparam int CELLS  = DIM * DIM;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int PROD_W = 2 * DATA_W;

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_MULTIPLY = 1'b1
  } cmd_t;

  typedef logic [DIM-1:0][DATA_W-1:0] vec_t;

  // per-stage load enables of the dot-product pipeline
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } stage_en_t;

endpackage
`default_nettype wire

@@ sv/mct_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
`default_nettype none
interface mct_in_if;
  logic                               valid;
  logic                               ready;
  mct_pkg::cmd_t                      command;
  logic [mct_pkg::IDX_W-1:0]          load_index;
  logic signed [mct_pkg::DATA_W-1:0]  load_value;
  logic signed [mct_pkg::DATA_W-1:0]  col_in_0;
  logic signed [mct_pkg::DATA_W-1:0]  col_in_1;
  logic signed [mct_pkg::DATA_W-1:0]  col_in_2;
  logic signed [mct_pkg::DATA_W-1:0]  col_in_3;

  modport source (
    output valid, command, load_index, load_value, col_in_0, col_in_1, col_in_2, col_in_3,
    input  ready
  );
  modport sink (
    input  valid, command, load_index, load_value, col_in_0, col_in_1, col_in_2, col_in_3,
    output ready
  );
endinterface

interface mct_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mct_pkg::DATA_W-1:0]  col_out_0;
  logic signed [mct_pkg::DATA_W-1:0]  col_out_1;
  logic signed [mct_pkg::DATA_W-1:0]  col_out_2;
  logic signed [mct_pkg::DATA_W-1:0]  col_out_3;
  logic                               saturated;

  modport source (
    output valid, col_out_0, col_out_1, col_out_2, col_out_3, saturated,
    input  ready
  );
  modport sink (
    input  valid, col_out_0, col_out_1, col_out_2, col_out_3, saturated,
    output ready
  );
endinterface
`default_nettype wire

@@ sv/mct_row_dot.sv @@
// Four-stage dot product of one left row with the right column: multiply, add, shift, saturate.
`default_nettype none
module mct_row_dot #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  wire                              clk,
  input  wire mct_pkg::stage_en_t          en,
  input  wire mct_pkg::vec_t               left_row,
  input  wire mct_pkg::vec_t               col,
  output logic [mct_pkg::DATA_W-1:0]       value,
  output logic                             clip
);

  localparam int PROD_W = mct_pkg::PROD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SH_W   = SUM_W - FRAC_BITS;
  localparam int CMP_W  = (SH_W > WORD_BITS) ? SH_W : WORD_BITS;
  localparam logic signed [CMP_W-1:0] MAXV =
    CMP_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic signed [CMP_W-1:0] MINV = ~MAXV;

  logic signed [PROD_W-1:0]         prod_r [mct_pkg::DIM];
  logic signed [PROD_W:0]           pair_r [2];
  logic        [SUM_W-1:0]          sum_nxt;
  logic signed [SH_W-1:0]           sh_r;
  logic signed [CMP_W-1:0]          ext;
  logic signed [CMP_W-1:0]          sat;
  logic                             clip_nxt;
  logic        [mct_pkg::DATA_W-1:0] value_r;
  logic                             clip_r;

  always_ff @(posedge clk) begin
    if (en.en1) begin
      for (int k = 0; k < mct_pkg::DIM; k++) begin
        prod_r[k] <= PROD_W'($signed(left_row[k])) * PROD_W'($signed(col[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.en2) begin
      pair_r[0] <= {prod_r[0][PROD_W-1], prod_r[0]} + {prod_r[1][PROD_W-1], prod_r[1]};
      pair_r[1] <= {prod_r[2][PROD_W-1], prod_r[2]} + {prod_r[3][PROD_W-1], prod_r[3]};
    end
  end

  assign sum_nxt = {pair_r[0][PROD_W], pair_r[0]} + {pair_r[1][PROD_W], pair_r[1]};

  // arithmetic shift: keep the upper bits of the exact sum
  always_ff @(posedge clk) begin
    if (en.en3) begin
      sh_r <= sum_nxt[SUM_W-1:FRAC_BITS];
    end
  end

  always_comb begin
    ext      = CMP_W'(sh_r);
    sat      = ext;
    clip_nxt = 1'b0;
    if (ext > MAXV) begin
      sat      = MAXV;
      clip_nxt = 1'b1;
    end else if (ext < MINV) begin
      sat      = MINV;
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en4) begin
      value_r <= sat[mct_pkg::DATA_W-1:0];
      clip_r  <= clip_nxt;
    end
  end

  assign value = value_r;
  assign clip  = clip_r;

endmodule
`default_nettype wire

@@ sv/matrix_4x4_column_transform.sv @@
// Top level: stored left matrix, pipeline control and four row dot-product pipelines.
//
// Use: in_bus carries command beats. A load beat (command 0) writes one element of
// the stored left matrix at load_index (row + 4*column) and produces no result.
// A multiply beat (command 1) carries one right column; out_bus returns the matching
// column of left * right in signed Q16.16, each element floor-shifted and saturated,
// with saturated set if any element was clipped.
// Path: a multiply passes the product, pair add, final add and shift, and saturate
// registers on its way to out_bus. Throughput: one beat per cycle of either kind
// while in_bus.ready is high; the sixteen products are formed in parallel at
// acceptance against the matrix as left by all earlier loads.
// Stall: out_bus.ready low holds the output register; stages behind it keep filling
// bubbles, and in_bus.ready drops only when all four stages hold data.
// Reset: rst_n (synchronous, active low) empties the pipeline and sets the left
// matrix to identity.
`default_nettype none
module matrix_4x4_column_transform #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  wire              clk,
  input  wire              rst_n,
  mct_in_if.sink           in_bus,
  mct_out_if.source        out_bus
);

  localparam int DIM = mct_pkg::DIM;
  localparam logic [mct_pkg::DATA_W-1:0] ONE = mct_pkg::DATA_W'(64'd1 << FRAC_BITS);

  logic [mct_pkg::DATA_W-1:0] mat_r [mct_pkg::CELLS];
  logic [3:0]                 vld_r;
  logic [3:0]                 vld_nxt;
  logic [3:0]                 rdy;
  logic                       mul_in;
  logic                       load_acc;
  mct_pkg::stage_en_t         stage_en;
  mct_pkg::vec_t              left_row [DIM];
  mct_pkg::vec_t              col_vec;
  logic [mct_pkg::DATA_W-1:0] row_val [DIM];
  logic [DIM-1:0]             row_clip;

  assign mul_in   = in_bus.valid && (in_bus.command == mct_pkg::CMD_MULTIPLY);
  assign load_acc = in_bus.valid && rdy[0] && (in_bus.command == mct_pkg::CMD_LOAD);

  always_comb begin
    rdy[3] = !vld_r[3] || out_bus.ready;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? mul_in : vld_r[0];
    for (int k = 1; k < 4; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
    stage_en.en1 = rdy[0] && mul_in;
    stage_en.en2 = rdy[1] && vld_r[0];
    stage_en.en3 = rdy[2] && vld_r[1];
    stage_en.en4 = rdy[3] && vld_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mct_pkg::CELLS; i++) begin
        mat_r[i] <= (i % (DIM + 1) == 0) ? ONE : '0;
      end
    end else if (load_acc) begin
      mat_r[in_bus.load_index] <= in_bus.load_value;
    end
  end

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int k = 0; k < DIM; k++) begin
        left_row[r][k] = mat_r[r + DIM * k];
      end
    end
    col_vec[0] = in_bus.col_in_0;
    col_vec[1] = in_bus.col_in_1;
    col_vec[2] = in_bus.col_in_2;
    col_vec[3] = in_bus.col_in_3;
  end

  for (genvar r = 0; r < DIM; r++) begin : g_row
    mct_row_dot #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS)
    ) u_row (
      .clk      (clk),
      .en       (stage_en),
      .left_row (left_row[r]),
      .col      (col_vec),
      .value    (row_val[r]),
      .clip     (row_clip[r])
    );
  end

  assign in_bus.ready      = rdy[0];
  assign out_bus.valid     = vld_r[3];
  assign out_bus.col_out_0 = row_val[0];
  assign out_bus.col_out_1 = row_val[1];
  assign out_bus.col_out_2 = row_val[2];
  assign out_bus.col_out_3 = row_val[3];
  assign out_bus.saturated = |row_clip;

  a_load_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> !vld_r[0])
    else $error("load beat entered the pipeline");

  a_hold_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && !out_bus.ready && vld_r[2]) |=> vld_r[2] && vld_r[3])
    else $error("stalled stage lost its beat");

  a_ready_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready |-> (!vld_r[0] || !vld_r[1] || !vld_r[2] || !vld_r[3] || out_bus.ready))
    else $error("ready raised with a full stalled pipeline");

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for matrix_4x4_column_transform: directed table plus random beats, checked by predictor.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int FRAC = 16;
  localparam int RANDOM_ITEMS = 1330;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AFTER = 400;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] NEG1 = 32'hFFFF_FFFF;
  localparam logic signed [67:0] HI_LIM = 68'sd2147483647;
  localparam logic signed [67:0] LO_LIM = -68'sd2147483648;

  typedef struct packed {
    mct_pkg::cmd_t cmd;
    logic [3:0]    idx;
    logic [31:0]   val;
    mct_pkg::vec_t col;
    logic          known;
    mct_pkg::vec_t want;
    logic          want_sat;
  } stim_row_t;

  typedef struct packed {
    mct_pkg::vec_t col;
    logic          sat;
  } column_result_t;

  logic clk;
  logic rst_n;
  int   err_count = 0;
  int   in_beats = 0;

  logic [31:0]    left_cells [mct_pkg::CELLS];
  column_result_t column_q [$];
  stim_row_t      cur_row;
  stim_row_t      directed_tbl [22];

  mct_in_if  in_ch ();
  mct_out_if out_ch ();

  matrix_4x4_column_transform #(
    .FRAC_BITS (FRAC),
    .WORD_BITS (32)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic mct_pkg::vec_t col4(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                         logic [31:0] d);
    mct_pkg::vec_t v;
    v[0] = a;
    v[1] = b;
    v[2] = c;
    v[3] = d;
    return v;
  endfunction

  function automatic column_result_t transform_column(mct_pkg::vec_t col);
    column_result_t res;
    logic signed [67:0] acc;
    logic signed [67:0] a;
    logic signed [67:0] b;
    res.sat = 1'b0;
    for (int r = 0; r < mct_pkg::DIM; r++) begin
      acc = '0;
      for (int k = 0; k < mct_pkg::DIM; k++) begin
        a = signed'(left_cells[r + mct_pkg::DIM * k]);
        b = signed'(col[k]);
        acc = acc + a * b;
      end
      acc = acc >>> FRAC;
      if (acc > HI_LIM) begin
        acc = HI_LIM;
        res.sat = 1'b1;
      end else if (acc < LO_LIM) begin
        acc = LO_LIM;
        res.sat = 1'b1;
      end
      res.col[r] = acc[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] pick_fixed();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3, 4: begin
        return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      end
      5, 6: begin
        return $urandom;
      end
      7: begin
        case ($urandom_range(0, 4))
          0: return MAXV;
          1: return MINV;
          2: return NEG1;
          3: return 32'd1;
          default: return 32'd0;
        endcase
      end
      default: begin
        return ($urandom_range(0, 1) != 0) ? ONE : (~ONE + 32'd1);
      end
    endcase
  endfunction

  task automatic log_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // beat monitor: sample at the falling edge, the transfer lands at the next rising edge
  always @(negedge clk) begin
    column_result_t exp_res;
    mct_pkg::vec_t got;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      in_beats++;
      if (cur_row.cmd == mct_pkg::CMD_LOAD) begin
        left_cells[cur_row.idx] = cur_row.val;
      end else if (cur_row.known) begin
        column_q.push_back('{col: cur_row.want, sat: cur_row.want_sat});
      end else begin
        column_q.push_back(transform_column(cur_row.col));
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = col4(out_ch.col_out_0, out_ch.col_out_1, out_ch.col_out_2, out_ch.col_out_3);
      if (column_q.size() == 0) begin
        log_error("result beat with nothing expected");
      end else begin
        exp_res = column_q.pop_front();
        for (int r = 0; r < mct_pkg::DIM; r++) begin
          if (got[r] !== exp_res.col[r])
            log_error($sformatf("col_out_%0d got %h want %h", r, got[r], exp_res.col[r]));
        end
        if (out_ch.saturated !== exp_res.sat)
          log_error($sformatf("saturated got %b want %b", out_ch.saturated, exp_res.sat));
      end
    end
  end

  // result side: random stall patterns, one long hold-off
  initial begin
    bit held;
    int unsigned seg_len;
    logic [7:0] pattern;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && in_beats >= HOLD_AFTER) begin
        held = 1'b1;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      seg_len = $urandom_range(4, 40);
      pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      for (int i = 0; i < seg_len; i++) begin
        out_ch.ready <= pattern[i % 8];
        @(posedge clk);
      end
    end
  end

  int unsigned burst_left = 0;

  task automatic offer(stim_row_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cur_row = r;
    in_ch.command    <= r.cmd;
    in_ch.load_index <= r.idx;
    in_ch.load_value <= r.val;
    in_ch.col_in_0   <= r.col[0];
    in_ch.col_in_1   <= r.col[1];
    in_ch.col_in_2   <= r.col[2];
    in_ch.col_in_3   <= r.col[3];
    in_ch.valid      <= 1'b1;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    stim_row_t r;
    mct_pkg::vec_t z;
    z = '0;
    for (int i = 0; i < mct_pkg::CELLS; i++)
      left_cells[i] = (i % (mct_pkg::DIM + 1) == 0) ? ONE : '0;
    directed_tbl = '{
      '{mct_pkg::CMD_MULTIPLY, 4'd15, MAXV, col4(ONE, 32'hFFFE_0000, MAXV, MINV), 1'b1,
        col4(ONE, 32'hFFFE_0000, MAXV, MINV), 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd9, NEG1,
        col4(32'd1, NEG1, 32'h1234_5678, 32'hEDCB_A988), 1'b1,
        col4(32'd1, NEG1, 32'h1234_5678, 32'hEDCB_A988), 1'b0},
      '{mct_pkg::CMD_LOAD, 4'd0, MAXV, col4(NEG1, NEG1, NEG1, NEG1), 1'b0, z, 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd0, 32'd0, col4(MAXV, 0, 0, 0), 1'b1,
        col4(MAXV, 0, 0, 0), 1'b1},
      '{mct_pkg::CMD_MULTIPLY, 4'd0, 32'd0, col4(MINV, 0, 0, 0), 1'b1,
        col4(MINV, 0, 0, 0), 1'b1},
      '{mct_pkg::CMD_LOAD, 4'd5, 32'd1, z, 1'b0, z, 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd0, 32'd0, col4(0, NEG1, 0, 0), 1'b1,
        col4(0, NEG1, 0, 0), 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd0, 32'd0, col4(0, 32'd1, 0, 0), 1'b1, z, 1'b0},
      '{mct_pkg::CMD_LOAD, 4'd15, MINV, z, 1'b0, z, 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd0, 32'd0, col4(0, 0, 0, MINV), 1'b1,
        col4(0, 0, 0, MAXV), 1'b1},
      '{mct_pkg::CMD_LOAD, 4'd10, MINV, z, 1'b0, z, 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd0, 32'd0, col4(0, 0, MAXV, 0), 1'b1,
        col4(0, 0, MINV, 0), 1'b1},
      '{mct_pkg::CMD_LOAD, 4'd3, MAXV, z, 1'b0, z, 1'b0},
      '{mct_pkg::CMD_LOAD, 4'd12, MINV, z, 1'b0, z, 1'b0},
      '{mct_pkg::CMD_LOAD, 4'd6, 32'h8000_0001, z, 1'b0, z, 1'b0},
      '{mct_pkg::CMD_LOAD, 4'd9, 32'hFFFF_8000, z, 1'b0, z, 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd0, 32'd0, col4(MAXV, MAXV, MAXV, MAXV), 1'b0, z, 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd0, 32'd0, col4(MINV, MINV, MINV, MINV), 1'b0, z, 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd0, 32'd0,
        col4(ONE, NEG1, 32'h0000_8000, 32'h0003_0000), 1'b0, z, 1'b0},
      '{mct_pkg::CMD_LOAD, 4'd0, ONE, col4(MAXV, MINV, NEG1, 32'd1), 1'b0, z, 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd0, 32'd0,
        col4(32'h0001_8000, 32'hFFFF_0000, 32'd1, NEG1), 1'b0, z, 1'b0},
      '{mct_pkg::CMD_MULTIPLY, 4'd7, MINV,
        col4(32'h0000_4000, MINV, ONE, 32'hFFFF_FFFE), 1'b0, z, 1'b0}
    };

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= mct_pkg::CMD_LOAD;
    in_ch.load_index <= '0;
    in_ch.load_value <= '0;
    in_ch.col_in_0   <= '0;
    in_ch.col_in_1   <= '0;
    in_ch.col_in_2   <= '0;
    in_ch.col_in_3   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tbl[i]) offer(directed_tbl[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = '0;
      r.cmd = ($urandom_range(0, 3) == 0) ? mct_pkg::CMD_LOAD : mct_pkg::CMD_MULTIPLY;
      r.idx = 4'($urandom);
      r.val = pick_fixed();
      r.col = col4(pick_fixed(), pick_fixed(), pick_fixed(), pick_fixed());
      offer(r);
    end
    in_ch.valid <= 1'b0;

    while (column_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
